@@ sv/sbh_pkg.sv @@
`timescale 1ns / 1ps

package sbh_pkg;

    localparam int DIGEST_WORDS = 8;
    localparam int SCHED_WORDS  = 16;

    localparam logic       ACT_ABSORB = 1'b0;
    localparam logic       ACT_FINISH = 1'b1;
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [5:0] LENGTH_POS = 6'd56;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] LEN_LAST   = 3'd7;
    localparam logic [2:0] WORD_LAST  = 3'(DIGEST_WORDS - 1);

    localparam logic [31:0] HASH_INIT [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_LEN   = 6'b000100,
        S_LOAD  = 6'b001000,
        S_ROUND = 6'b010000,
        S_FINAL = 6'b100000
    } t_state;

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

@@ sv/sha256_byte_stream_hasher.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Signals                       Payload (lowest bit first)
// -------   ---  ----------------------------  --------------------------------------
// in item   in   i_tvalid i_tready i_tdata     tdata: data_byte[7:0]
//                i_tuser                       tuser: action[0]
// out item  out  o_tvalid o_tready o_tdata     tdata: digest_word[31:0]
//                o_tuser o_tlast               tuser: word_index[2:0]; tlast: last_word
//
// Absorb items are taken while idle. Each full 64-byte block then holds input off
// through one read of the 16-word block memory, 64 rounds of the single round unit
// and the fold into the hash words. A finish item walks the padding one
// byte per cycle (up to 72 bytes plus one or two blocks). Output of the eight words
// runs from its own register and overlaps absorbs of the next message; a finish
// waits until the previous digest has drained. Reset is synchronous; no clearing pass.
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tvalid,
    output logic        i_tready,
    input  logic [7:0]  i_tdata,   // data_byte[7:0]
    input  logic        i_tuser,   // action[0]
    output logic        o_tvalid,
    input  logic        o_tready,
    output logic [31:0] o_tdata,   // digest_word[31:0]
    output logic [2:0]  o_tuser,   // word_index[2:0]
    output logic        o_tlast
);
    import sbh_pkg::*;

    t_state       r_state, n_state;
    logic [5:0]   r_fill, n_fill;
    logic [23:0]  r_part, n_part;
    logic [60:0]  r_msg, n_msg;
    logic [63:0]  r_len, n_len;
    logic [2:0]   r_lcnt, n_lcnt;
    logic         r_fin, n_fin;
    logic         r_tail, n_tail;
    logic [5:0]   r_rnd, n_rnd;
    logic         r_obusy, n_obusy;
    logic [2:0]   r_oidx, n_oidx;

    logic [31:0]  r_mem [SCHED_WORDS];
    logic [31:0]  r_rdata;
    logic [3:0]   rd_addr;

    logic [31:0]  r_hash [DIGEST_WORDS];
    logic [31:0]  r_v [DIGEST_WORDS];
    logic [31:0]  r_w [SCHED_WORDS];
    logic [31:0]  r_dig [DIGEST_WORDS];

    logic         in_fire;
    logic         last_blk;
    logic         push_en;
    logic [7:0]   push_byte;
    logic [31:0]  w_t, t1, t2, ch, maj;

    assign in_fire  = i_tvalid && i_tready;
    assign i_tready = (r_state == S_IDLE) && ((i_tuser == ACT_ABSORB) || !r_obusy);
    assign last_blk = r_fin && r_tail;

    assign o_tvalid = r_obusy;
    assign o_tdata  = r_dig[r_oidx];
    assign o_tuser  = r_oidx;
    assign o_tlast  = (r_oidx == WORD_LAST);

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_part    = r_part;
        n_msg     = r_msg;
        n_len     = r_len;
        n_lcnt    = r_lcnt;
        n_fin     = r_fin;
        n_tail    = r_tail;
        n_rnd     = r_rnd;
        n_obusy   = r_obusy;
        n_oidx    = r_oidx;
        push_en   = 1'b0;
        push_byte = ZERO_BYTE;

        if (r_obusy && o_tready) begin
            if (r_oidx == WORD_LAST) begin
                n_obusy = 1'b0;
            end else begin
                n_oidx = r_oidx + 3'd1;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    push_en = 1'b1;
                    if (i_tuser == ACT_ABSORB) begin
                        push_byte = i_tdata;
                        n_msg     = r_msg + 61'd1;
                        if (r_fill == FILL_LAST) begin
                            n_state = S_LOAD;
                        end
                    end else begin
                        push_byte = PAD_BYTE;
                        n_len     = {r_msg, 3'b000};
                        n_fin     = 1'b1;
                        n_tail    = 1'b0;
                        n_state   = (r_fill == FILL_LAST) ? S_LOAD : S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_fill == LENGTH_POS) begin
                    n_state = S_LEN;
                    n_lcnt  = '0;
                end else begin
                    push_en = 1'b1;
                    if (r_fill == FILL_LAST) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LEN: begin
                push_en   = 1'b1;
                push_byte = r_len[63:56];
                n_len     = {r_len[55:0], 8'h00};
                n_lcnt    = r_lcnt + 3'd1;
                if (r_lcnt == LEN_LAST) begin
                    n_tail  = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_rnd   = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == ROUND_LAST) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                n_state = S_IDLE;
                if (r_fin) begin
                    if (r_tail) begin
                        n_fin   = 1'b0;
                        n_tail  = 1'b0;
                        n_msg   = '0;
                        n_obusy = 1'b1;
                        n_oidx  = '0;
                    end else begin
                        n_state = S_PAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (push_en) begin
            n_fill = r_fill + 6'd1;
            n_part = {r_part[15:0], push_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_msg   <= '0;
            r_lcnt  <= '0;
            r_fin   <= 1'b0;
            r_tail  <= 1'b0;
            r_rnd   <= '0;
            r_obusy <= 1'b0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_msg   <= n_msg;
            r_lcnt  <= n_lcnt;
            r_fin   <= n_fin;
            r_tail  <= n_tail;
            r_rnd   <= n_rnd;
            r_obusy <= n_obusy;
            r_oidx  <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_part <= n_part;
        r_len  <= n_len;
    end

    assign rd_addr = (r_state == S_LOAD) ? '0 : (r_rnd[3:0] + 4'd1);

    always_ff @(posedge i_clk) begin
        if (push_en && (r_fill[1:0] == 2'b11)) begin
            r_mem[r_fill[5:2]] <= {r_part, push_byte};
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_comb begin
        if (r_rnd < 6'(SCHED_WORDS)) begin
            w_t = r_rdata;
        end else begin
            w_t = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
        end
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1  = r_v[7] + big_sigma1(r_v[4]) + ch + ROUND_K[r_rnd] + w_t;
        t2  = big_sigma0(r_v[0]) + maj;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_v <= r_hash;
        end else if (r_state == S_ROUND) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            for (int i = 0; i < SCHED_WORDS - 1; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[SCHED_WORDS - 1] <= w_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= HASH_INIT;
        end else if (r_state == S_FINAL) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                r_hash[i] <= last_blk ? HASH_INIT[i] : (r_hash[i] + r_v[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FINAL) && last_blk) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                r_dig[i] <= r_hash[i] + r_v[i];
            end
        end
    end

endmodule

@@ sv/sbh_checker.sv @@
`timescale 1ns / 1ps

module sbh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_tvalid,
    input logic        i_tready,
    input logic        i_tuser,
    input logic        o_tvalid,
    input logic        o_tready,
    input logic [31:0] o_tdata,
    input logic [2:0]  o_tuser,
    input logic        o_tlast
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_tvalid)
        else $error("output item valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid && !o_tready |=> o_tvalid && $stable(o_tdata) && $stable(o_tuser))
        else $error("stalled output item changed");

    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid |-> (o_tlast == (o_tuser == 3'd7)))
        else $error("tlast does not mark the eighth word");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid && o_tready && !o_tlast |=>
            o_tvalid && (o_tuser == 3'($past(o_tuser) + 3'd1)))
        else $error("digest words not in order");

    a_finish_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tvalid && i_tready && i_tuser |-> !o_tvalid)
        else $error("finish item taken while digest still pending");

endmodule

bind sha256_byte_stream_hasher sbh_checker u_sbh_checker (.*);
